[src/assert_macros.svh]
// Assertion macros shared by the list engine RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_NEVER(name, cond, msg)
`endif
`endif

[src/ile_pkg.sv]
// Shared types and constants of the indexed list engine.
// No dependencies.
package ile_pkg;
	localparam int CAPACITY_DEF  = 256;
	localparam int WORD_BITS_DEF = 32;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [KIND_W-1:0] {
		K_INS_POS   = 3'd0,
		K_INS_FRONT = 3'd1,
		K_INS_BACK  = 3'd2,
		K_WRITE     = 3'd3,
		K_REM_POS   = 3'd4,
		K_REM_FRONT = 3'd5,
		K_REM_BACK  = 3'd6,
		K_REVERSE   = 3'd7
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		S_OK    = 2'd0,
		S_RANGE = 2'd1,
		S_EMPTY = 2'd2,
		S_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CL_INSERT  = 2'd0,
		CL_WRITE   = 2'd1,
		CL_REMOVE  = 2'd2,
		CL_REVERSE = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		AT_POS   = 2'd0,
		AT_FRONT = 2'd1,
		AT_BACK  = 2'd2
	} where_t;

	// Decoded operation travelling from front to back
	typedef struct packed {
		cls_t                      cls;
		where_t                    at;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} qitem_t;
endpackage

[src/ile_req_if.sv]
// Request channel of the list engine: kind, value, position.
// Depends on ile_pkg.
interface ile_req_if import ile_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, kind, value, position, input ready);
	modport sink (input valid, kind, value, position, output ready);
endinterface

[src/ile_rsp_if.sv]
// Response channel of the list engine: status, removed value, count.
// Depends on ile_pkg.
interface ile_rsp_if import ile_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] removed_value;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, status, removed_value, count, input ready);
	modport sink (input valid, status, removed_value, count, output ready);
endinterface

[src/ile_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/ile_front.sv]
// Front part: accept requests, classify them, hold them in a two-entry queue.
// Depends on ile_pkg and ile_req_if.
module ile_front import ile_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ile_req_if.sink   req,
	output logic      q_vld,
	output qitem_t    q_item,
	input  logic      q_rdy
);
	qitem_t     slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	qitem_t     dec;
	logic       push;
	logic       pop;

	// Classify the request kind
	always_comb begin
		dec.value    = req.value;
		dec.position = req.position;
		case (kind_t'(req.kind))
			K_INS_POS:   begin dec.cls = CL_INSERT;  dec.at = AT_POS;   end
			K_INS_FRONT: begin dec.cls = CL_INSERT;  dec.at = AT_FRONT; end
			K_INS_BACK:  begin dec.cls = CL_INSERT;  dec.at = AT_BACK;  end
			K_WRITE:     begin dec.cls = CL_WRITE;   dec.at = AT_POS;   end
			K_REM_POS:   begin dec.cls = CL_REMOVE;  dec.at = AT_POS;   end
			K_REM_FRONT: begin dec.cls = CL_REMOVE;  dec.at = AT_FRONT; end
			K_REM_BACK:  begin dec.cls = CL_REMOVE;  dec.at = AT_BACK;  end
			default:     begin dec.cls = CL_REVERSE; dec.at = AT_POS;   end
		endcase
	end

	assign req.ready = (fill_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_vld     = (fill_q != 2'd0);
	assign q_item    = slot_q[rd_q];
	assign pop       = q_vld && q_rdy;

	// Store classified items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= dec;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end
endmodule

[src/ile_back.sv]
// Back part: link walker and sequencer over the node stores, result register.
// Depends on ile_pkg, ile_rsp_if, ile_ram and assert_macros.svh.
`include "assert_macros.svh"
module ile_back import ile_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_vld,
	input  qitem_t    q_item,
	output logic      q_rdy,
	ile_rsp_if.source rsp
);
	localparam int IW  = $clog2(CAPACITY + 1);
	localparam int NAW = $clog2(CAPACITY);
	localparam int PW  = (IW > POS_W) ? IW : POS_W;
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);
	localparam logic [IW-1:0] CAP = IW'(CAPACITY);

	typedef enum logic [3:0] {
		ST_IDLE, ST_WALK, ST_FOUND, ST_INS_RD, ST_ALLOC, ST_ALLOC_RD,
		ST_LINK1, ST_LINK2, ST_RM_RD, ST_RM_FREE
	} state_t;

	state_t                      st_q;
	logic                        rev_q;
	logic [IW-1:0]               first_q, last_q, count_q, free_q, fresh_q;
	logic [IW-1:0]               cur_q, prev_q, next_q, n_q, cnt_q;
	cls_t                        cls_q;
	logic [WORD_BITS-1:0]        word_q;
	logic signed [WORD_BITS-1:0] got_q;
	logic                        out_vld_q;
	status_t                     out_status_q;
	logic signed [VALUE_W-1:0]   out_removed_q;
	logic [COUNT_W-1:0]          out_count_q;

	logic [IW-1:0]        fwd_rd, bwd_rd, nx_rd, pv_rd, lhead, ltail;
	logic [WORD_BITS-1:0] val_rd;
	logic [IW-1:0]        rd_addr;
	logic                 nx_we, pv_we, free_we, val_we;
	logic [IW-1:0]        nx_wa, nx_wd, pv_wa, pv_wd, val_wa;
	logic                 fwd_we, bwd_we;
	logic [IW-1:0]        fwd_wa, fwd_wd, bwd_wa, bwd_wd;

	logic                 start;
	status_t              chk;
	logic [PW-1:0]        pos_ext, cnt_ext, tgt;
	logic                 ins_end, rem_back;
	logic signed [63:0]   vx, gx;
	logic [WORD_BITS-1:0] in_word;

	assign nx_rd = rev_q ? bwd_rd : fwd_rd;
	assign pv_rd = rev_q ? fwd_rd : bwd_rd;
	assign lhead = rev_q ? last_q : first_q;
	assign ltail = rev_q ? first_q : last_q;

	assign vx      = 64'(q_item.value);
	assign in_word = vx[WORD_BITS-1:0];
	assign gx      = 64'(got_q);

	assign start = (st_q == ST_IDLE) && q_vld && !out_vld_q;
	assign q_rdy = start;

	// Classify against the current count
	always_comb begin
		pos_ext  = PW'(q_item.position);
		cnt_ext  = PW'(count_q);
		tgt      = pos_ext;
		chk      = S_OK;
		ins_end  = 1'b0;
		rem_back = 1'b0;
		case (q_item.cls)
			CL_INSERT: begin
				if (q_item.at == AT_FRONT) tgt = '0;
				else if (q_item.at == AT_BACK) tgt = cnt_ext;
				ins_end = (tgt == cnt_ext);
				if (tgt > cnt_ext) chk = S_RANGE;
				else if (count_q == CAP) chk = S_FULL;
			end
			CL_WRITE: begin
				if (count_q == '0) chk = S_EMPTY;
				else if (pos_ext >= cnt_ext) chk = S_RANGE;
			end
			CL_REMOVE: begin
				if (q_item.at != AT_POS) tgt = '0;
				rem_back = (q_item.at == AT_BACK);
				if (count_q == '0) chk = S_EMPTY;
				else if (q_item.at == AT_POS && pos_ext >= cnt_ext) chk = S_RANGE;
			end
			default: chk = S_OK;
		endcase
	end

	// Drive read address and logical writes per state
	always_comb begin
		rd_addr = cur_q;
		nx_we = 1'b0; nx_wa = n_q; nx_wd = next_q;
		pv_we = 1'b0; pv_wa = n_q; pv_wd = prev_q;
		free_we = 1'b0;
		val_we = 1'b0; val_wa = cur_q;
		case (st_q)
			ST_IDLE:     rd_addr = lhead;
			ST_WALK:     rd_addr = nx_rd;
			ST_ALLOC:    rd_addr = free_q;
			ST_FOUND: begin
				val_we = (cls_q == CL_WRITE);
			end
			ST_LINK1: begin
				val_we = 1'b1; val_wa = n_q;
				nx_we  = 1'b1;
				pv_we  = 1'b1;
			end
			ST_LINK2: begin
				nx_we = (prev_q != NIL); nx_wa = prev_q; nx_wd = n_q;
				pv_we = (next_q != NIL); pv_wa = next_q; pv_wd = n_q;
			end
			ST_RM_RD: begin
				nx_we = (pv_rd != NIL); nx_wa = pv_rd; nx_wd = nx_rd;
				pv_we = (nx_rd != NIL); pv_wa = nx_rd; pv_wd = pv_rd;
			end
			ST_RM_FREE:  free_we = 1'b1;
			default:     rd_addr = cur_q;
		endcase
	end

	// Map logical links onto the physical forward and backward stores
	always_comb begin
		if (free_we) begin
			fwd_we = 1'b1; fwd_wa = cur_q; fwd_wd = free_q;
			bwd_we = 1'b0; bwd_wa = cur_q; bwd_wd = free_q;
		end else if (rev_q) begin
			fwd_we = pv_we; fwd_wa = pv_wa; fwd_wd = pv_wd;
			bwd_we = nx_we; bwd_wa = nx_wa; bwd_wd = nx_wd;
		end else begin
			fwd_we = nx_we; fwd_wa = nx_wa; fwd_wd = nx_wd;
			bwd_we = pv_we; bwd_wa = pv_wa; bwd_wd = pv_wd;
		end
	end

	ile_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_fwd (
		.clk(clk), .we(fwd_we), .waddr(fwd_wa[NAW-1:0]), .wdata(fwd_wd),
		.raddr(rd_addr[NAW-1:0]), .rdata(fwd_rd)
	);

	ile_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_bwd (
		.clk(clk), .we(bwd_we), .waddr(bwd_wa[NAW-1:0]), .wdata(bwd_wd),
		.raddr(rd_addr[NAW-1:0]), .rdata(bwd_rd)
	);

	ile_ram #(.WIDTH(WORD_BITS), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(val_we), .waddr(val_wa[NAW-1:0]), .wdata(word_q),
		.raddr(rd_addr[NAW-1:0]), .rdata(val_rd)
	);

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.removed_value = out_removed_q;
	assign rsp.count         = out_count_q;

	// Sequencer state, list registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			rev_q     <= 1'b0;
			first_q   <= NIL;
			last_q    <= NIL;
			count_q   <= '0;
			free_q    <= '0;
			fresh_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) out_vld_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						cls_q  <= q_item.cls;
						word_q <= in_word;
						if (q_item.cls == CL_REVERSE || chk != S_OK) begin
							if (q_item.cls == CL_REVERSE) rev_q <= ~rev_q;
							out_vld_q     <= 1'b1;
							out_status_q  <= chk;
							out_removed_q <= '0;
							out_count_q   <= COUNT_W'(count_q);
						end else if (q_item.cls == CL_INSERT && ins_end) begin
							prev_q <= ltail;
							next_q <= NIL;
							st_q   <= ST_ALLOC;
						end else if (rem_back) begin
							cur_q <= ltail;
							st_q  <= ST_FOUND;
						end else if (tgt == '0) begin
							cur_q <= lhead;
							st_q  <= ST_FOUND;
						end else begin
							cnt_q <= IW'(tgt);
							st_q  <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (cnt_q == IW'(1)) begin
						cur_q <= nx_rd;
						st_q  <= ST_FOUND;
					end else begin
						cnt_q <= cnt_q - IW'(1);
					end
				end
				ST_FOUND: begin
					case (cls_q)
						CL_WRITE: begin
							out_vld_q     <= 1'b1;
							out_status_q  <= S_OK;
							out_removed_q <= '0;
							out_count_q   <= COUNT_W'(count_q);
							st_q          <= ST_IDLE;
						end
						CL_REMOVE: st_q <= ST_RM_RD;
						default: begin
							next_q <= cur_q;
							st_q   <= ST_INS_RD;
						end
					endcase
				end
				ST_INS_RD: begin
					prev_q <= pv_rd;
					st_q   <= ST_ALLOC;
				end
				ST_ALLOC: begin
					n_q <= free_q;
					if (free_q == fresh_q) begin
						free_q  <= free_q + IW'(1);
						fresh_q <= fresh_q + IW'(1);
						st_q    <= ST_LINK1;
					end else begin
						st_q <= ST_ALLOC_RD;
					end
				end
				ST_ALLOC_RD: begin
					free_q <= fwd_rd;
					st_q   <= ST_LINK1;
				end
				ST_LINK1: st_q <= ST_LINK2;
				ST_LINK2: begin
					if (prev_q == NIL) begin
						if (rev_q) last_q <= n_q; else first_q <= n_q;
					end
					if (next_q == NIL) begin
						if (rev_q) first_q <= n_q; else last_q <= n_q;
					end
					count_q       <= count_q + IW'(1);
					out_vld_q     <= 1'b1;
					out_status_q  <= S_OK;
					out_removed_q <= '0;
					out_count_q   <= COUNT_W'(count_q + IW'(1));
					st_q          <= ST_IDLE;
				end
				ST_RM_RD: begin
					got_q <= val_rd;
					if (pv_rd == NIL) begin
						if (rev_q) last_q <= nx_rd; else first_q <= nx_rd;
					end
					if (nx_rd == NIL) begin
						if (rev_q) first_q <= pv_rd; else last_q <= pv_rd;
					end
					st_q <= ST_RM_FREE;
				end
				ST_RM_FREE: begin
					free_q        <= cur_q;
					count_q       <= count_q - IW'(1);
					out_vld_q     <= 1'b1;
					out_status_q  <= S_OK;
					out_removed_q <= gx[VALUE_W-1:0];
					out_count_q   <= COUNT_W'(count_q - IW'(1));
					st_q          <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_count_cap, count_q > CAP, "entry count exceeds capacity")
	`ASSERT_CLK(a_count_step, (count_q == $past(count_q)) || (count_q == $past(count_q) + IW'(1)) || (count_q == $past(count_q) - IW'(1)), "count moved by more than one")
	`ASSERT_CLK(a_head_empty, (st_q == ST_IDLE) |-> ((count_q == '0) == (first_q == NIL)), "head link disagrees with count")
	`ASSERT_CLK(a_start_free, start |-> !out_vld_q, "operation started with result pending")
endmodule

[src/indexed_list_engine_core.sv]
// Top level of the indexed list engine: front queue plus back sequencer.
// Depends on ile_pkg, ile_req_if, ile_rsp_if, ile_front and ile_back.
//
// Usage: the req channel carries one operation per transfer (kind, value,
// position); the rsp channel returns exactly one result per operation
// (status, removed_value, count) in order. The list holds up to CAPACITY
// words of WORD_BITS bits; values are kept sign-extended to 32 bits.
// Operations pass through the back sequencer: reverse and rejected ops
//   give their result straight from idle; front/back ops skip the link
//   walk; positional ops walk the links over the entries before the
//   target. The link walk, one node store read per cycle, sets the cost
//   of an operation; operations are carried out one at a time.
// A two-entry queue in front takes requests while the back is busy or a
// result waits; req.ready drops when it is full. The result stays in its
// register until rsp.ready; a stalled receiver halts the back only.
// Reset (arst_n low) empties the list and the queue; no clearing pass is
// needed, and req.ready is high as soon as reset is released.
module indexed_list_engine_core import ile_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ile_req_if.sink   req,
	ile_rsp_if.source rsp
);
	logic   q_vld;
	logic   q_rdy;
	qitem_t q_item;

	ile_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.q_vld(q_vld), .q_item(q_item), .q_rdy(q_rdy)
	);

	ile_back #(.CAPACITY(CAPACITY), .WORD_BITS(WORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_vld(q_vld), .q_item(q_item), .q_rdy(q_rdy), .rsp(rsp)
	);
endmodule

[bench/tb_indexed_list_engine_core.sv]
// Self-checking bench for indexed_list_engine_core: directed table, then random list traffic.
// Depends on ile_pkg, ile_req_if, ile_rsp_if and the core; predicts results with a queue model.
`timescale 1ns / 1ps

module tb_indexed_list_engine_core;
	import ile_pkg::*;

	localparam int  LIST_CAP  = 256;
	localparam int  RAND_OPS  = 1400;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		kind_t                     kind;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
		bit                        typed;
		status_t                   status;
		logic signed [VALUE_W-1:0] removed_value;
		logic [COUNT_W-1:0]        count;
	} list_op_t;

	typedef struct {
		status_t                   status;
		logic signed [VALUE_W-1:0] removed_value;
		logic [COUNT_W-1:0]        count;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ile_req_if req_ch ();
	ile_rsp_if rsp_ch ();

	indexed_list_engine_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// stimulus, predicted list contents and pending results
	list_op_t                  op_list[$];
	logic signed [VALUE_W-1:0] list_words[$];
	list_result_t              pending_results[$];
	int  ops_taken = 0;
	int  errors = 0;
	longint cycles = 0;
	int  gen_count = 0;

	always #1 clk = ~clk;

	// hard stop on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("indexed_list_engine_core regression: fail");
			$finish;
		end
	end

	// apply one operation to the predicted list and return its result
	function automatic list_result_t apply_op(list_op_t o);
		list_result_t r;
		int p;
		int n;
		logic signed [VALUE_W-1:0] t;
		r.status = S_OK;
		r.removed_value = '0;
		n = list_words.size();
		case (o.kind)
			K_INS_POS, K_INS_FRONT, K_INS_BACK: begin
				p = (o.kind == K_INS_FRONT) ? 0 : (o.kind == K_INS_BACK) ? n : int'(o.position);
				if (p > n) r.status = S_RANGE;
				else if (n >= LIST_CAP) r.status = S_FULL;
				else list_words.insert(p, o.value);
			end
			K_WRITE: begin
				p = int'(o.position);
				if (n == 0) r.status = S_EMPTY;
				else if (p >= n) r.status = S_RANGE;
				else list_words[p] = o.value;
			end
			K_REM_POS, K_REM_FRONT, K_REM_BACK: begin
				p = (o.kind == K_REM_FRONT) ? 0 : (o.kind == K_REM_BACK) ? n - 1 : int'(o.position);
				if (n == 0) r.status = S_EMPTY;
				else if (p >= n) r.status = S_RANGE;
				else begin
					r.removed_value = list_words[p];
					list_words.delete(p);
				end
			end
			default: begin
				for (int i = 0; i < n / 2; i++) begin
					t = list_words[i];
					list_words[i] = list_words[n - 1 - i];
					list_words[n - 1 - i] = t;
				end
			end
		endcase
		r.count = COUNT_W'(list_words.size());
		return r;
	endfunction

	function automatic void add_op(kind_t k, logic signed [VALUE_W-1:0] v, int pos, bit typed,
			status_t st = S_OK, logic signed [VALUE_W-1:0] rv = '0, int cnt = 0);
		list_op_t o;
		o.kind = k;
		o.value = v;
		o.position = POS_W'(pos);
		o.typed = typed;
		o.status = st;
		o.removed_value = rv;
		o.count = COUNT_W'(cnt);
		op_list.push_back(o);
	endfunction

	// track only the list length while generating, to steer positions
	function automatic bit gen_track(kind_t k, int pos);
		bit ok;
		ok = 1'b0;
		case (k)
			K_INS_POS, K_INS_FRONT, K_INS_BACK: begin
				if (k != K_INS_POS || pos <= gen_count) begin
					if (gen_count < LIST_CAP) begin
						gen_count++;
						ok = 1'b1;
					end
				end
			end
			K_REM_POS, K_REM_FRONT, K_REM_BACK: begin
				if (gen_count > 0 && (k != K_REM_POS || pos < gen_count)) begin
					gen_count--;
					ok = 1'b1;
				end
			end
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic build_random();
		bit grow;
		int target;
		int full_hits;
		int pos;
		int hi;
		kind_t k;
		bit ok;
		grow = 1'b1;
		target = 6;
		full_hits = 0;
		for (int i = 0; i < RAND_OPS; i++) begin
			// one long fill to capacity early on, then small lists
			if (i == 250) begin
				grow = 1'b1;
				target = LIST_CAP;
			end
			if (grow && gen_count >= target && (target < LIST_CAP || full_hits >= 5)) begin
				grow = 1'b0;
				target = $urandom_range(4);
			end else if (!grow && gen_count <= target) begin
				grow = 1'b1;
				target = $urandom_range(12, 1);
			end
			if ($urandom_range(99) < 70)
				k = grow ? kind_t'($urandom_range(2)) : kind_t'($urandom_range(6, 4));
			else
				k = grow ? kind_t'($urandom_range(7, 3)) : kind_t'($urandom_range(3));
			hi = (k == K_INS_POS) ? gen_count : (gen_count > 0 ? gen_count - 1 : 0);
			pos = ($urandom_range(99) < 85) ? $urandom_range(hi) : $urandom_range(511);
			if (gen_count == LIST_CAP && k <= K_INS_BACK) full_hits++;
			ok = gen_track(k, pos);
			add_op(k, pick_word(), pos, 1'b0);
		end
	endtask

	// reference transfers: predict on request, check on response
	always @(posedge clk) begin
		list_result_t r;
		list_result_t want;
		list_op_t o;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				o = op_list[ops_taken];
				r = apply_op(o);
				if (o.typed) begin
					r.status = o.status;
					r.removed_value = o.removed_value;
					r.count = o.count;
				end
				pending_results.push_back(r);
				ops_taken <= ops_taken + 1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status=%0d removed=%0d count=%0d", $time,
						rsp_ch.status, rsp_ch.removed_value, rsp_ch.count);
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							rsp_ch.status);
					end
					if (rsp_ch.removed_value !== want.removed_value) begin
						errors++;
						$display("%0t: removed_value expected %0d actual %0d", $time,
							want.removed_value, rsp_ch.removed_value);
					end
					if (rsp_ch.count !== want.count) begin
						errors++;
						$display("%0t: count expected %0d actual %0d", $time, want.count,
							rsp_ch.count);
					end
				end
			end
		end
	end

	function automatic bit quiet_window();
		return ops_taken >= 900 && ops_taken < 1100;
	endfunction

	// receiver: random backpressure plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && ops_taken >= 400) begin
				held = 1'b1;
				repeat (800) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				rsp_ch.ready <= quiet_window() ? 1'b1 : ($urandom_range(99) >= 30);
				@(posedge clk);
			end
		end
	end

	// sender and end of run
	initial begin
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.value = '0;
		req_ch.position = '0;

		// directed table: empty list, extremes, error codes
		add_op(K_REM_FRONT, '0, 0, 1'b1, S_EMPTY, '0, 0);
		add_op(K_REM_BACK, '0, 0, 1'b1, S_EMPTY, '0, 0);
		add_op(K_WRITE, 32'sd9, 0, 1'b1, S_EMPTY, '0, 0);
		add_op(K_REM_POS, '0, 0, 1'b1, S_EMPTY, '0, 0);
		add_op(K_INS_POS, 32'sd1, 1, 1'b1, S_RANGE, '0, 0);
		add_op(K_REVERSE, '0, 0, 1'b1, S_OK, '0, 0);
		add_op(K_INS_POS, 32'sh7fffffff, 0, 1'b1, S_OK, '0, 1);
		add_op(K_INS_FRONT, 32'sh80000000, 0, 1'b1, S_OK, '0, 2);
		add_op(K_INS_BACK, -32'sd1, 0, 1'b1, S_OK, '0, 3);
		add_op(K_INS_POS, 32'sd4, 511, 1'b1, S_RANGE, '0, 3);
		add_op(K_WRITE, 32'sd4, 3, 1'b1, S_RANGE, '0, 3);
		add_op(K_WRITE, '0, 0, 1'b1, S_OK, '0, 3);
		add_op(K_REVERSE, '0, 0, 1'b1, S_OK, '0, 3);
		add_op(K_REM_FRONT, '0, 0, 1'b1, S_OK, -32'sd1, 2);
		add_op(K_REM_BACK, '0, 0, 1'b1, S_OK, '0, 1);
		add_op(K_REM_POS, '0, 1, 1'b1, S_RANGE, '0, 1);
		add_op(K_REM_POS, '0, 256, 1'b1, S_RANGE, '0, 1);
		add_op(K_REM_POS, '0, 0, 1'b1, S_OK, 32'sh7fffffff, 0);
		add_op(K_INS_POS, 32'sd5, 0, 1'b0);
		add_op(K_REVERSE, '0, 0, 1'b0);
		add_op(K_INS_POS, 32'sd3, 1, 1'b0);
		add_op(K_INS_POS, 32'sd7, 1, 1'b0);
		add_op(K_WRITE, 32'sh55aa55aa, 2, 1'b0);
		add_op(K_REM_POS, '0, 1, 1'b0);
		add_op(K_REM_BACK, '0, 0, 1'b0);
		add_op(K_REM_FRONT, '0, 0, 1'b0);
		build_random();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (op_list[i]) begin
			// drain everything once mid-run
			if (i == 700) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			while (!quiet_window() && $urandom_range(99) < 30) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
			req_ch.valid <= 1'b1;
			req_ch.kind <= op_list[i].kind;
			req_ch.value <= op_list[i].value;
			req_ch.position <= op_list[i].position;
			@(posedge clk);
			while (!req_ch.ready) @(posedge clk);
		end
		req_ch.valid <= 1'b0;
		@(posedge clk);

		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("indexed_list_engine_core regression: pass");
		end else begin
			$display("indexed_list_engine_core regression: fail");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/ile_pkg.sv
src/ile_req_if.sv
src/ile_rsp_if.sv
src/ile_ram.sv
src/ile_front.sv
src/ile_back.sv
src/indexed_list_engine_core.sv
bench/tb_indexed_list_engine_core.sv
